### hw/rtl/cfa_pkg.sv
// shared types and constants of the contiguous fit allocator
`timescale 1ns / 1ps
package cfa_pkg;

   // request and response field widths
   localparam int OPCODE_W = 1;
   localparam int PID_W    = 8;
   localparam int SIZE_W   = 13;
   localparam int STATUS_W = 2;
   localparam int START_W  = 10;
   localparam int COUNT_W  = 11;
   localparam int WASTE_W  = 2;
   localparam int POLICY_W = 2;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_ALLOC   = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_RELEASE = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_HOLE    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND  = 2'd3;

   // fit policies
   localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
   localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
   localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_NEED,
      ST_SCAN,
      ST_DECIDE,
      ST_SHIFT,
      ST_WRITE1,
      ST_WRITE2,
      ST_LARGEST,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [START_W-1:0]  start_block;
      logic [COUNT_W-1:0]  block_count;
      logic [WASTE_W-1:0]  slack_kb;
      logic [COUNT_W-1:0]  free_blocks;
      logic [COUNT_W-1:0]  largest_hole;
   } result_type;

endpackage

### hw/rtl/cfa_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module cfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/cfa_ctrl.sv
// sequencer: table scan, entry shift, split or merge write-back, largest hole scan
`timescale 1ns / 1ps
module cfa_ctrl #(
   parameter int TOTAL_BLOCK_COUNT = 1024,
   parameter int BLOCK_KB          = 4,
   parameter int MAX_SEGMENTS      = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_take,
   input  logic [cfa_pkg::OPCODE_W-1:0]           req_opcode,
   input  logic [cfa_pkg::PID_W-1:0]              req_process_id,
   input  logic [cfa_pkg::SIZE_W-1:0]             req_size_kb,
   input  logic [cfa_pkg::POLICY_W-1:0]           fit_policy,
   output logic                                   idle,
   output logic                                   ram_wr_en,
   output logic [$clog2(MAX_SEGMENTS)-1:0]        ram_wr_addr,
   output logic [$clog2(TOTAL_BLOCK_COUNT) + $clog2(TOTAL_BLOCK_COUNT+1)
                 + cfa_pkg::PID_W:0]              ram_wr_data,
   output logic [$clog2(MAX_SEGMENTS)-1:0]        ram_rd_addr,
   input  logic [$clog2(TOTAL_BLOCK_COUNT) + $clog2(TOTAL_BLOCK_COUNT+1)
                 + cfa_pkg::PID_W:0]              ram_rd_data,
   input  logic                                   slot_free,
   output logic                                   rsp_load,
   output cfa_pkg::result_type                    rsp_data
);
   import cfa_pkg::*;

   localparam int SW   = $clog2(TOTAL_BLOCK_COUNT);
   localparam int TW   = $clog2(TOTAL_BLOCK_COUNT + 1);
   localparam int AW   = $clog2(MAX_SEGMENTS);
   localparam int CW   = $clog2(MAX_SEGMENTS + 1);
   localparam int IW   = CW + 1;
   localparam int NW   = SIZE_W + 1;
   localparam int CMPW = (NW > TW) ? NW : TW;
   localparam int SH   = SIZE_W + 1 + $clog2(BLOCK_KB) + 1;
   localparam int RW   = SH + 1;
   localparam int PW   = NW + RW;
   localparam int RECIP = ((1 << SH) + BLOCK_KB - 1) / BLOCK_KB;

   typedef struct packed {
      logic [SW-1:0]    start;
      logic [TW-1:0]    len;
      logic             free;
      logic [PID_W-1:0] owner;
   } entry_type;

   ctrl_state_type      state_ff, state_in;
   logic [OPCODE_W-1:0] opcode_ff, opcode_in;
   logic [PID_W-1:0]    pid_ff, pid_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [NW-1:0]       need_ff, need_in;
   logic [CW-1:0]       count_ff, count_in, count_new_ff, count_new_in;
   logic [TW-1:0]       free_total_ff, free_total_in;
   logic [TW-1:0]       largest_ff, largest_in;
   logic [TW-1:0]       max_ff, max_in;
   logic [CW-1:0]       rd_idx_ff, rd_idx_in;
   logic                dv_ff, dv_in;
   logic [AW-1:0]       dv_idx_ff, dv_idx_in;
   logic                found_ff, found_in;
   logic [AW-1:0]       pick_idx_ff, pick_idx_in;
   logic [TW-1:0]       pick_len_ff, pick_len_in;
   logic [SW-1:0]       pick_start_ff, pick_start_in;
   logic                prev_free_ff, prev_free_in;
   logic [TW-1:0]       prev_len_ff, prev_len_in;
   logic [SW-1:0]       prev_start_ff, prev_start_in;
   logic                mprev_ff, mprev_in;
   logic [TW-1:0]       mprev_len_ff, mprev_len_in;
   logic [SW-1:0]       mprev_start_ff, mprev_start_in;
   logic                mnext_ff, mnext_in;
   logic [TW-1:0]       mnext_len_ff, mnext_len_in;
   logic [AW-1:0]       sh_src_ff, sh_src_in, sh_last_ff, sh_last_in;
   logic [AW-1:0]       sh_dst_ff, sh_dst_in;
   logic                sh_up_ff, sh_up_in, sh_issue_ff, sh_issue_in;
   logic                sh_pend_ff, sh_pend_in;
   logic [1:0]          sh_dist_ff, sh_dist_in;
   logic [AW-1:0]       wr1_addr_ff, wr1_addr_in, wr2_addr_ff, wr2_addr_in;
   entry_type           wr1_data_ff, wr1_data_in, wr2_data_ff, wr2_data_in;
   logic                wr2_en_ff, wr2_en_in;
   result_type          res_ff, res_in;

   entry_type           rd_entry;
   logic                scan_issue, scan_end, split, cand, take_hole;
   logic [NW-1:0]       sum_kb;
   logic [PW-1:0]       prod;
   logic [IW-1:0]       first_src;
   logic [1:0]          merge_gap;
   logic [TW-1:0]       merged_len;

   assign rd_entry   = entry_type'(ram_rd_data);
   assign scan_issue = (rd_idx_ff < count_ff);
   assign scan_end   = !scan_issue && !dv_ff;
   assign sum_kb     = NW'(size_ff) + NW'(BLOCK_KB - 1);
   assign prod       = PW'(sum_kb) * PW'(RECIP);
   assign split      = (CMPW'(pick_len_ff) != CMPW'(need_ff));
   assign cand       = rd_entry.free && (CMPW'(rd_entry.len) >= CMPW'(need_ff));
   assign merge_gap  = {1'b0, mprev_ff} + {1'b0, mnext_ff};
   assign first_src  = IW'(pick_idx_ff) + IW'(1) + IW'(mnext_ff);
   assign merged_len = pick_len_ff + (mprev_ff ? mprev_len_ff : TW'(0))
                       + (mnext_ff ? mnext_len_ff : TW'(0));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         count_ff      <= CW'(1);
         free_total_ff <= TW'(TOTAL_BLOCK_COUNT);
         largest_ff    <= TW'(TOTAL_BLOCK_COUNT);
         dv_ff         <= 1'b0;
         sh_issue_ff   <= 1'b0;
         sh_pend_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         free_total_ff <= free_total_in;
         largest_ff    <= largest_in;
         dv_ff         <= dv_in;
         sh_issue_ff   <= sh_issue_in;
         sh_pend_ff    <= sh_pend_in;
      end
      opcode_ff      <= opcode_in;
      pid_ff         <= pid_in;
      size_ff        <= size_in;
      need_ff        <= need_in;
      count_new_ff   <= count_new_in;
      max_ff         <= max_in;
      rd_idx_ff      <= rd_idx_in;
      dv_idx_ff      <= dv_idx_in;
      found_ff       <= found_in;
      pick_idx_ff    <= pick_idx_in;
      pick_len_ff    <= pick_len_in;
      pick_start_ff  <= pick_start_in;
      prev_free_ff   <= prev_free_in;
      prev_len_ff    <= prev_len_in;
      prev_start_ff  <= prev_start_in;
      mprev_ff       <= mprev_in;
      mprev_len_ff   <= mprev_len_in;
      mprev_start_ff <= mprev_start_in;
      mnext_ff       <= mnext_in;
      mnext_len_ff   <= mnext_len_in;
      sh_src_ff      <= sh_src_in;
      sh_last_ff     <= sh_last_in;
      sh_dst_ff      <= sh_dst_in;
      sh_up_ff       <= sh_up_in;
      sh_dist_ff     <= sh_dist_in;
      wr1_addr_ff    <= wr1_addr_in;
      wr1_data_ff    <= wr1_data_in;
      wr2_addr_ff    <= wr2_addr_in;
      wr2_data_ff    <= wr2_data_in;
      wr2_en_ff      <= wr2_en_in;
      res_ff         <= res_in;
   end

   always_comb begin
      state_in       = state_ff;
      opcode_in      = opcode_ff;
      pid_in         = pid_ff;
      size_in        = size_ff;
      need_in        = need_ff;
      count_in       = count_ff;
      count_new_in   = count_new_ff;
      free_total_in  = free_total_ff;
      largest_in     = largest_ff;
      max_in         = max_ff;
      rd_idx_in      = rd_idx_ff;
      dv_in          = 1'b0;
      dv_idx_in      = dv_idx_ff;
      found_in       = found_ff;
      pick_idx_in    = pick_idx_ff;
      pick_len_in    = pick_len_ff;
      pick_start_in  = pick_start_ff;
      prev_free_in   = prev_free_ff;
      prev_len_in    = prev_len_ff;
      prev_start_in  = prev_start_ff;
      mprev_in       = mprev_ff;
      mprev_len_in   = mprev_len_ff;
      mprev_start_in = mprev_start_ff;
      mnext_in       = mnext_ff;
      mnext_len_in   = mnext_len_ff;
      sh_src_in      = sh_src_ff;
      sh_last_in     = sh_last_ff;
      sh_dst_in      = sh_dst_ff;
      sh_up_in       = sh_up_ff;
      sh_dist_in     = sh_dist_ff;
      sh_issue_in    = sh_issue_ff;
      sh_pend_in     = 1'b0;
      wr1_addr_in    = wr1_addr_ff;
      wr1_data_in    = wr1_data_ff;
      wr2_addr_in    = wr2_addr_ff;
      wr2_data_in    = wr2_data_ff;
      wr2_en_in      = wr2_en_ff;
      res_in         = res_ff;
      take_hole      = 1'b0;
      idle           = 1'b0;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = '0;
      ram_wr_data    = '0;
      ram_rd_addr    = rd_idx_ff[AW-1:0];
      rsp_load       = 1'b0;

      rsp_data              = res_ff;
      rsp_data.free_blocks  = COUNT_W'(free_total_ff);
      rsp_data.largest_hole = COUNT_W'(largest_ff);

      // sequential table read shared by both scans
      if ((state_ff == ST_SCAN || state_ff == ST_LARGEST) && scan_issue) begin
         rd_idx_in = rd_idx_ff + CW'(1);
         dv_in     = 1'b1;
         dv_idx_in = rd_idx_ff[AW-1:0];
      end

      case (state_ff)
         ST_INIT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = '0;
            ram_wr_data = entry_type'{start: '0, len: TW'(TOTAL_BLOCK_COUNT),
                                      free: 1'b1, owner: '0};
            state_in    = ST_IDLE;
         end
         ST_IDLE: begin
            idle = 1'b1;
            if (req_take) begin
               opcode_in    = req_opcode;
               pid_in       = req_process_id;
               size_in      = req_size_kb;
               rd_idx_in    = '0;
               found_in     = 1'b0;
               prev_free_in = 1'b0;
               mprev_in     = 1'b0;
               mnext_in     = 1'b0;
               state_in     = (req_opcode == OP_ALLOC) ? ST_NEED : ST_SCAN;
            end
         end
         ST_NEED: begin
            need_in = prod[SH +: NW];
            if (size_ff == '0) begin
               res_in   = '0;
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (dv_ff) begin
               if (opcode_ff == OP_ALLOC) begin
                  if (cand) begin
                     if (fit_policy == POLICY_BEST) begin
                        take_hole = !found_ff || rd_entry.len <= pick_len_ff;
                     end else if (fit_policy == POLICY_WORST) begin
                        take_hole = !found_ff || rd_entry.len > pick_len_ff;
                     end else begin
                        take_hole = !found_ff;
                     end
                     if (take_hole) begin
                        found_in      = 1'b1;
                        pick_idx_in   = dv_idx_ff;
                        pick_len_in   = rd_entry.len;
                        pick_start_in = rd_entry.start;
                     end
                  end
               end else begin
                  if (!found_ff && !rd_entry.free && rd_entry.owner == pid_ff) begin
                     found_in       = 1'b1;
                     pick_idx_in    = dv_idx_ff;
                     pick_len_in    = rd_entry.len;
                     pick_start_in  = rd_entry.start;
                     mprev_in       = prev_free_ff;
                     mprev_len_in   = prev_len_ff;
                     mprev_start_in = prev_start_ff;
                  end
                  if (found_ff && dv_idx_ff == pick_idx_ff + AW'(1)) begin
                     mnext_in     = rd_entry.free;
                     mnext_len_in = rd_entry.len;
                  end
                  prev_free_in  = rd_entry.free;
                  prev_len_in   = rd_entry.len;
                  prev_start_in = rd_entry.start;
               end
            end
            if (scan_end) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            res_in      = '0;
            sh_issue_in = 1'b1;
            if (opcode_ff == OP_ALLOC) begin
               if (!found_ff) begin
                  res_in.status = STATUS_NO_HOLE;
                  state_in      = ST_DONE;
               end else if (split && count_ff >= CW'(MAX_SEGMENTS)) begin
                  res_in.status = STATUS_TABLE_FULL;
                  state_in      = ST_DONE;
               end else begin
                  res_in.status      = STATUS_DONE;
                  res_in.start_block = START_W'(pick_start_ff);
                  res_in.block_count = COUNT_W'(need_ff);
                  res_in.slack_kb    = WASTE_W'(need_ff) * WASTE_W'(BLOCK_KB)
                                       - WASTE_W'(size_ff);
                  wr1_addr_in   = pick_idx_ff;
                  wr1_data_in   = entry_type'{start: pick_start_ff, len: TW'(need_ff),
                                              free: 1'b0, owner: pid_ff};
                  wr2_en_in     = split;
                  wr2_addr_in   = pick_idx_ff + AW'(1);
                  wr2_data_in   = entry_type'{start: pick_start_ff + SW'(need_ff),
                                              len: pick_len_ff - TW'(need_ff),
                                              free: 1'b1, owner: '0};
                  free_total_in = free_total_ff - TW'(need_ff);
                  count_new_in  = count_ff + CW'(split);
                  // open a slot above the hole by moving the tail up one entry
                  sh_src_in  = AW'(count_ff - CW'(1));
                  sh_last_in = pick_idx_ff + AW'(1);
                  sh_up_in   = 1'b1;
                  sh_dist_in = 2'd1;
                  if (split && (CW'(pick_idx_ff) + CW'(1) < count_ff)) begin
                     state_in = ST_SHIFT;
                  end else begin
                     state_in = ST_WRITE1;
                  end
               end
            end else begin
               if (!found_ff) begin
                  res_in.status = STATUS_NOT_FOUND;
                  state_in      = ST_DONE;
               end else begin
                  res_in.status      = STATUS_DONE;
                  res_in.start_block = START_W'(pick_start_ff);
                  res_in.block_count = COUNT_W'(pick_len_ff);
                  wr1_addr_in   = mprev_ff ? pick_idx_ff - AW'(1) : pick_idx_ff;
                  wr1_data_in   = entry_type'{start: mprev_ff ? mprev_start_ff
                                                              : pick_start_ff,
                                              len: merged_len, free: 1'b1, owner: '0};
                  wr2_en_in     = 1'b0;
                  free_total_in = free_total_ff + pick_len_ff;
                  count_new_in  = count_ff - CW'(merge_gap);
                  // close the gap left by merged entries
                  sh_src_in  = AW'(first_src);
                  sh_last_in = AW'(count_ff - CW'(1));
                  sh_up_in   = 1'b0;
                  sh_dist_in = merge_gap;
                  if (merge_gap != 2'd0 && first_src < IW'(count_ff)) begin
                     state_in = ST_SHIFT;
                  end else begin
                     state_in = ST_WRITE1;
                  end
               end
            end
         end
         ST_SHIFT: begin
            ram_rd_addr = sh_src_ff;
            if (sh_issue_ff) begin
               sh_pend_in = 1'b1;
               sh_dst_in  = sh_up_ff ? sh_src_ff + AW'(1) : sh_src_ff - AW'(sh_dist_ff);
               if (sh_src_ff == sh_last_ff) begin
                  sh_issue_in = 1'b0;
               end else begin
                  sh_src_in = sh_up_ff ? sh_src_ff - AW'(1) : sh_src_ff + AW'(1);
               end
            end
            if (sh_pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = sh_dst_ff;
               ram_wr_data = ram_rd_data;
            end
            if (!sh_issue_ff && !sh_pend_ff) begin
               state_in = ST_WRITE1;
            end
         end
         ST_WRITE1: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = wr1_addr_ff;
            ram_wr_data = wr1_data_ff;
            count_in    = count_new_ff;
            rd_idx_in   = '0;
            max_in      = '0;
            state_in    = wr2_en_ff ? ST_WRITE2 : ST_LARGEST;
         end
         ST_WRITE2: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = wr2_addr_ff;
            ram_wr_data = wr2_data_ff;
            state_in    = ST_LARGEST;
         end
         ST_LARGEST: begin
            if (dv_ff && rd_entry.free && rd_entry.len > max_ff) begin
               max_in = rd_entry.len;
            end
            if (scan_end) begin
               largest_in = max_ff;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/contiguous_fit_allocator_top.sv
// top level of the contiguous fit allocator: policy register, response register, table ram
`timescale 1ns / 1ps
// Contiguous fit allocator. A pool of TOTAL_BLOCK_COUNT blocks of BLOCK_KB kilobytes is
// kept as an address-ordered table of up to MAX_SEGMENTS segments in one ram. An allocate
// request rounds its size up to whole blocks and takes a hole by first, best or worst fit
// (csr register, reset to best fit; code 3 acts as first fit); a release frees the lowest
// segment of the process and merges free neighbours. Each request gets one response with
// status, segment, rounding slack and the free totals after the operation. One request is
// worked on at a time: a request that changes the table holds the block through two table
// scans (hole search, then largest hole), each with one ram read per segment, and through
// the moves of the entries that open or close a table slot. A rejected request needs only
// the hole search. After reset the block writes the initial hole before it takes a request.
// A finished response waits in its own register, so the next request may be taken while
// it is still stalled.
module contiguous_fit_allocator_top #(
   parameter int TOTAL_BLOCK_COUNT = 1024,
   parameter int BLOCK_KB          = 4,
   parameter int MAX_SEGMENTS      = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [cfa_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic [cfa_pkg::PID_W-1:0]         req_process_id,
   input  logic [cfa_pkg::SIZE_W-1:0]        req_size_kb,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [cfa_pkg::STATUS_W-1:0]      rsp_status,
   output logic [cfa_pkg::START_W-1:0]       rsp_start_block,
   output logic [cfa_pkg::COUNT_W-1:0]       rsp_block_count,
   output logic [cfa_pkg::WASTE_W-1:0]       rsp_slack_kb,
   output logic [cfa_pkg::COUNT_W-1:0]       rsp_free_blocks,
   output logic [cfa_pkg::COUNT_W-1:0]       rsp_largest_hole,
   // policy register
   input  logic                              csr_write_enable,
   input  logic [cfa_pkg::POLICY_W-1:0]      csr_write_data
);
   import cfa_pkg::*;

   localparam int AW = $clog2(MAX_SEGMENTS);
   // table entry: start, length, free flag, owner
   localparam int EW = $clog2(TOTAL_BLOCK_COUNT) + $clog2(TOTAL_BLOCK_COUNT + 1) + 1 + PID_W;

   logic [POLICY_W-1:0] fit_policy_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_ff, rsp_in;

   logic                idle, req_take, slot_free, rsp_load;
   result_type          rsp_data;
   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr, ram_rd_addr;
   logic [EW-1:0]       ram_wr_data, ram_rd_data;

   assign req_stall = !idle;
   assign req_take  = req_valid && !req_stall;
   // response register frees up when empty or being taken this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = rsp_data;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_policy_ff <= POLICY_BEST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            fit_policy_ff <= csr_write_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_start_block  = rsp_ff.start_block;
   assign rsp_block_count  = rsp_ff.block_count;
   assign rsp_slack_kb     = rsp_ff.slack_kb;
   assign rsp_free_blocks  = rsp_ff.free_blocks;
   assign rsp_largest_hole = rsp_ff.largest_hole;

   cfa_ctrl #(
      .TOTAL_BLOCK_COUNT (TOTAL_BLOCK_COUNT),
      .BLOCK_KB          (BLOCK_KB),
      .MAX_SEGMENTS      (MAX_SEGMENTS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_take       (req_take),
      .req_opcode     (req_opcode),
      .req_process_id (req_process_id),
      .req_size_kb    (req_size_kb),
      .fit_policy     (fit_policy_ff),
      .idle           (idle),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data),
      .slot_free      (slot_free),
      .rsp_load       (rsp_load),
      .rsp_data       (rsp_data)
   );

   // segment table
   cfa_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_SEGMENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

### test/cfa_checker.sv
// response checker and allocator predictor for the contiguous fit allocator test
`timescale 1ns / 1ps
module cfa_checker #(
   parameter int TOTAL_BLOCK_COUNT = 1024,
   parameter int BLOCK_KB          = 4,
   parameter int MAX_SEGMENTS      = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [cfa_pkg::OPCODE_W-1:0]     req_opcode,
   input  logic [cfa_pkg::PID_W-1:0]        req_process_id,
   input  logic [cfa_pkg::SIZE_W-1:0]       req_size_kb,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [cfa_pkg::STATUS_W-1:0]     rsp_status,
   input  logic [cfa_pkg::START_W-1:0]      rsp_start_block,
   input  logic [cfa_pkg::COUNT_W-1:0]      rsp_block_count,
   input  logic [cfa_pkg::WASTE_W-1:0]      rsp_slack_kb,
   input  logic [cfa_pkg::COUNT_W-1:0]      rsp_free_blocks,
   input  logic [cfa_pkg::COUNT_W-1:0]      rsp_largest_hole,
   input  logic                             csr_write_enable,
   input  logic [cfa_pkg::POLICY_W-1:0]     csr_write_data,
   output int                               errors,
   output int                               pending,
   output int                               checked,
   output int                               full_hits
);
   import cfa_pkg::*;

   int seg_start[MAX_SEGMENTS];
   int seg_len[MAX_SEGMENTS];
   bit seg_free[MAX_SEGMENTS];
   int seg_owner[MAX_SEGMENTS];
   int seg_count;
   int free_total;
   int largest;
   logic [POLICY_W-1:0] policy;
   result_type awaited_responses[$];

   function automatic void refresh_largest();
      largest = 0;
      for (int i = 0; i < seg_count; i++)
         if (seg_free[i] && seg_len[i] > largest) largest = seg_len[i];
   endfunction

   function automatic void drop_entry(int idx);
      for (int i = idx; i + 1 < seg_count; i++) begin
         seg_start[i] = seg_start[i+1];
         seg_len[i]   = seg_len[i+1];
         seg_free[i]  = seg_free[i+1];
         seg_owner[i] = seg_owner[i+1];
      end
      seg_count--;
   endfunction

   function automatic result_type predict_response(logic [OPCODE_W-1:0] op,
                                                   logic [PID_W-1:0] pid,
                                                   logic [SIZE_W-1:0] size);
      result_type r;
      int need;
      int pick;
      int at;
      int blk;
      bit found;
      r = '0;
      r.status = STATUS_DONE;
      found = 0;
      pick = 0;
      if (op == OP_ALLOC) begin
         need = (int'(size) + BLOCK_KB - 1) / BLOCK_KB;
         if (need == 0) begin
         end else if (need > largest) begin
            r.status = STATUS_NO_HOLE;
         end else begin
            for (int i = 0; i < seg_count; i++) begin
               if (seg_free[i] && seg_len[i] >= need) begin
                  if (policy == POLICY_BEST) begin
                     if (!found || seg_len[i] <= seg_len[pick]) begin pick = i; found = 1; end
                  end else if (policy == POLICY_WORST) begin
                     if (!found || seg_len[i] > seg_len[pick]) begin pick = i; found = 1; end
                  end else if (!found) begin
                     pick = i;
                     found = 1;
                  end
               end
            end
            if (!found) begin
               r.status = STATUS_NO_HOLE;
            end else if (seg_len[pick] != need && seg_count >= MAX_SEGMENTS) begin
               r.status = STATUS_TABLE_FULL;
            end else begin
               blk = seg_start[pick];
               if (seg_len[pick] != need) begin
                  for (int i = seg_count; i > pick; i--) begin
                     seg_start[i] = seg_start[i-1];
                     seg_len[i]   = seg_len[i-1];
                     seg_free[i]  = seg_free[i-1];
                     seg_owner[i] = seg_owner[i-1];
                  end
                  seg_count++;
                  seg_start[pick+1] = blk + need;
                  seg_len[pick+1]   = seg_len[pick] - need;
                  seg_free[pick+1]  = 1;
               end
               seg_len[pick]   = need;
               seg_free[pick]  = 0;
               seg_owner[pick] = pid;
               r.start_block = START_W'(blk);
               r.block_count = COUNT_W'(need);
               r.slack_kb    = WASTE_W'(need * BLOCK_KB - int'(size));
               free_total -= need;
               refresh_largest();
            end
         end
      end else begin
         at = -1;
         for (int i = 0; i < seg_count; i++)
            if (at < 0 && !seg_free[i] && seg_owner[i] == pid) at = i;
         if (at < 0) begin
            r.status = STATUS_NOT_FOUND;
         end else begin
            r.start_block = START_W'(seg_start[at]);
            r.block_count = COUNT_W'(seg_len[at]);
            seg_free[at] = 1;
            free_total += seg_len[at];
            if (at + 1 < seg_count && seg_free[at+1]) begin
               seg_len[at] += seg_len[at+1];
               drop_entry(at + 1);
            end
            if (at > 0 && seg_free[at-1]) begin
               seg_len[at-1] += seg_len[at];
               drop_entry(at);
            end
            refresh_largest();
         end
      end
      r.free_blocks  = COUNT_W'(free_total);
      r.largest_hole = COUNT_W'(largest);
      return r;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         errors++;
         if (errors <= 40)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         for (int i = 0; i < MAX_SEGMENTS; i++) begin
            seg_start[i] = 0; seg_len[i] = 0; seg_free[i] = 0; seg_owner[i] = 0;
         end
         seg_len[0]  = TOTAL_BLOCK_COUNT;
         seg_free[0] = 1;
         seg_count   = 1;
         free_total  = TOTAL_BLOCK_COUNT;
         largest     = TOTAL_BLOCK_COUNT;
         policy      = POLICY_BEST;
         errors      = 0;
         checked     = 0;
         full_hits   = 0;
         awaited_responses.delete();
      end else begin
         if (csr_write_enable) policy = csr_write_data;
         if (rsp_valid && !rsp_stall) begin
            if (awaited_responses.size() == 0) begin
               errors++;
               $display("%0t: response with none expected, actual status %0d",
                        $time, rsp_status);
            end else begin
               want = awaited_responses.pop_front();
               checked++;
               check_field("status", want.status, rsp_status);
               check_field("start_block", want.start_block, rsp_start_block);
               check_field("block_count", want.block_count, rsp_block_count);
               check_field("slack_kb", want.slack_kb, rsp_slack_kb);
               check_field("free_blocks", want.free_blocks, rsp_free_blocks);
               check_field("largest_hole", want.largest_hole, rsp_largest_hole);
            end
         end
         if (req_valid && !req_stall) begin
            want = predict_response(req_opcode, req_process_id, req_size_kb);
            if (want.status == STATUS_TABLE_FULL) full_hits++;
            awaited_responses.push_back(want);
         end
      end
      pending = awaited_responses.size();
   end
endmodule

### test/contiguous_fit_allocator_top_test.sv
// stimulus, handshake pressure and verdict for the contiguous fit allocator
`timescale 1ns / 1ps
module contiguous_fit_allocator_top_test;
   import cfa_pkg::*;

   localparam logic [POLICY_W-1:0] POLICY_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 400;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [OPCODE_W-1:0] req_opcode = OP_ALLOC;
   logic [PID_W-1:0]    req_process_id = '0;
   logic [SIZE_W-1:0]   req_size_kb = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [STATUS_W-1:0] rsp_status;
   logic [START_W-1:0]  rsp_start_block;
   logic [COUNT_W-1:0]  rsp_block_count;
   logic [WASTE_W-1:0]  rsp_slack_kb;
   logic [COUNT_W-1:0]  rsp_free_blocks;
   logic [COUNT_W-1:0]  rsp_largest_hole;
   logic csr_write_enable = 0;
   logic [POLICY_W-1:0] csr_write_data = '0;

   int errors, pending, checked, full_hits;
   int sender_idle_pct = 0;   // chance in a hundred of a gap before a request
   int receiver_stall_pct = 0;
   int requests_sent = 0;
   int quiet_cycles = 0;

   always #1 clock = ~clock;

   contiguous_fit_allocator_top DUT (
      .clock, .reset,
      .req_valid, .req_stall, .req_opcode, .req_process_id, .req_size_kb,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_start_block, .rsp_block_count,
      .rsp_slack_kb, .rsp_free_blocks, .rsp_largest_hole,
      .csr_write_enable, .csr_write_data
   );

   cfa_checker u_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_opcode, .req_process_id, .req_size_kb,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_start_block, .rsp_block_count,
      .rsp_slack_kb, .rsp_free_blocks, .rsp_largest_hole,
      .csr_write_enable, .csr_write_data,
      .errors, .pending, .checked, .full_hits
   );

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);

   // watchdog: cycles with neither channel moving
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d responses outstanding", pending);
         $display("TB_ERROR");
         $finish;
      end
   end

   // one request: optional gap with valid low, then hold until taken
   task automatic send_request(logic [OPCODE_W-1:0] op, logic [PID_W-1:0] pid,
                               logic [SIZE_W-1:0] size);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid      <= 1;
      req_opcode     <= op;
      req_process_id <= pid;
      req_size_kb    <= size;
      do @(posedge clock); while (req_stall);
      requests_sent++;
   endtask

   // let every response drain, then the block is idle
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_policy(logic [POLICY_W-1:0] value);
      drain();
      csr_write_enable <= 1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   // random request with mostly small sizes and a narrow owner range so releases hit
   task automatic send_random_request();
      logic [OPCODE_W-1:0] op;
      logic [PID_W-1:0] pid;
      logic [SIZE_W-1:0] size;
      int r;
      op  = ($urandom_range(99) < 55) ? OP_ALLOC : OP_RELEASE;
      pid = ($urandom_range(99) < 80) ? PID_W'($urandom_range(31))
                                      : PID_W'($urandom_range(255));
      r = $urandom_range(99);
      if (r < 70)      size = SIZE_W'($urandom_range(1, 64));
      else if (r < 90) size = SIZE_W'($urandom_range(65, 1024));
      else if (r < 97) size = SIZE_W'($urandom_range(1025, 4096));
      else             size = SIZE_W'($urandom_range(8191));
      send_request(op, pid, size);
   endtask

   // fill the table with single-block segments until it overflows
   task automatic fill_table(bit fixed_owners);
      for (int i = 0; i < 66; i++)
         send_request(OP_ALLOC, fixed_owners ? PID_W'(i) : PID_W'($urandom_range(31)),
                      SIZE_W'($urandom_range(1, 4)));
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed part at reset policy (best fit)
      send_request(OP_ALLOC, 8'd0, 13'd0);        // zero size
      send_request(OP_ALLOC, 8'd1, 13'd8191);     // too large
      send_request(OP_ALLOC, 8'd1, 13'd4096);     // whole pool, exact fit
      send_request(OP_ALLOC, 8'd2, 13'd1);        // nothing free
      send_request(OP_RELEASE, 8'd1, 13'd0);
      send_request(OP_RELEASE, 8'd1, 13'd0);      // absent owner
      send_request(OP_ALLOC, 8'd255, 13'd1);      // waste of three
      send_request(OP_ALLOC, 8'd3, 13'd40);
      send_request(OP_ALLOC, 8'd255, 13'd8);      // same owner twice
      send_request(OP_ALLOC, 8'd4, 13'd100);
      send_request(OP_RELEASE, 8'd255, 13'd0);    // frees the lower one
      send_request(OP_RELEASE, 8'd4, 13'd0);      // merge with hole above
      send_request(OP_RELEASE, 8'd3, 13'd0);      // merge with hole below
      send_request(OP_RELEASE, 8'd255, 13'd0);    // merge on both sides
      send_request(OP_RELEASE, 8'd0, 13'd8191);   // size ignored, absent owner

      // table overflow, then exact fit with a full table, then empty it
      write_policy(POLICY_FIRST);
      fill_table(1);
      send_request(OP_ALLOC, 8'd70, 13'd3844);
      for (int i = 0; i < 64; i++) send_request(OP_RELEASE, PID_W'(i), 13'd0);
      send_request(OP_RELEASE, 8'd70, 13'd0);

      // four phases of pressure, each under its own fit policy
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct = 0;  receiver_stall_pct = 0;  write_policy(POLICY_FIRST);
            end
            1: begin
               sender_idle_pct = 83; receiver_stall_pct = 0;  write_policy(POLICY_WORST);
            end
            2: begin
               sender_idle_pct = 0;  receiver_stall_pct = 83; write_policy(POLICY_UNUSED);
            end
            default: begin
               sender_idle_pct = 36; receiver_stall_pct = 36; write_policy(POLICY_BEST);
            end
         endcase
         fill_table(0);
         for (int i = 0; i < 110; i++) send_random_request();
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d requests under all four fit policy codes and four pressure settings",
               requests_sent);
      $display("compared %0d responses, %0d of them table-full rejections", checked, full_hits);
      if (errors == 0 && pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

### sim.f
hw/rtl/cfa_pkg.sv
hw/rtl/cfa_ram.sv
hw/rtl/cfa_ctrl.sv
hw/rtl/contiguous_fit_allocator_top.sv
test/cfa_checker.sv
test/contiguous_fit_allocator_top_test.sv
